// File: design/assert_macros.svh
// Assertion macros shared by the filter cascade RTL.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// File: design/bwic_pkg.sv
// Shared types and constants of the IIR filter cascade.
// Used by the multiply-accumulate unit and the top level; depends on nothing.
`default_nettype none

package bwic_pkg;

	// Parameter defaults.
	localparam int MAX_SECT_DEF    = 8;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int COEF_BITS_DEF   = 32;

	// Fixed widths.
	localparam int HIST_W   = 48;
	localparam int SLOTS    = 6;
	localparam int FIELD_W  = 32;
	localparam int CFG_W    = 32;
	localparam int CFG_IX_W = 2;

	// Input actions.
	localparam logic [1:0] ACT_FILTER = 2'd0;
	localparam logic [1:0] ACT_LOAD   = 2'd1;
	localparam logic [1:0] ACT_CLEAR  = 2'd2;
	localparam logic [1:0] ACT_SPARE  = 2'd3;

	// Filter modes.
	localparam logic [1:0] MODE_LP = 2'd0;
	localparam logic [1:0] MODE_HP = 2'd1;
	localparam logic [1:0] MODE_BP = 2'd2;
	localparam logic [1:0] MODE_BS = 2'd3;

	// Register indexes.
	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_SECTS  = 2'd1;
	localparam logic [1:0] REG_STOP_R = 2'd2;
	localparam logic [1:0] REG_STOP_S = 2'd3;

	// Coefficient slot of the section gain.
	localparam logic [2:0] SLOT_GAIN = 3'd0;

	// Small multipliers for the power-of-two numerator taps.
	localparam logic signed [2:0] M_ZERO    = 3'sd0;
	localparam logic signed [2:0] M_ONE     = 3'sd1;
	localparam logic signed [2:0] M_TWO     = 3'sd2;
	localparam logic signed [2:0] M_NEG_TWO = -3'sd2;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FB,
		ST_FB_END,
		ST_NUM,
		ST_NUM_END,
		ST_GAIN,
		ST_GAIN_END,
		ST_WB,
		ST_OUT
	} st_t;

	// Control of the multiply-accumulate unit.
	typedef struct packed {
		logic              valid;
		logic              ld;
		logic              p2;
		logic signed [2:0] m;
	} mac_ctl_t;

	// Status of the multiply-accumulate unit.
	typedef struct packed {
		logic rdy;
		logic idle;
		logic clip;
	} mac_sts_t;

endpackage

`default_nettype wire

// File: design/bwic_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
`default_nettype none

module bwic_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: design/bwic_mac.sv
// Shared multiply-accumulate unit: one coefficient times one 48-bit history word
// per term, split into two half products, with floor shift and 48-bit saturation.
// Depends on bwic_pkg.
`default_nettype none

module bwic_mac #(
	parameter int CW   = 32,
	parameter int FRAC = 26
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire bwic_pkg::mac_ctl_t                  ctl,
	input  wire logic signed [CW:0]                  c_in,
	input  wire logic signed [bwic_pkg::HIST_W-1:0]  w_in,
	input  wire logic signed [bwic_pkg::HIST_W-1:0]  ld_x,
	output bwic_pkg::mac_sts_t                       sts,
	output logic signed      [bwic_pkg::HIST_W-1:0]  sat_val
);

	localparam int HW    = bwic_pkg::HIST_W;
	localparam int LO_W  = HW / 2;
	localparam int PW    = (CW + 26 > FRAC + 51) ? CW + 26 : FRAC + 51;
	localparam int ACC_W = ((CW + 49 > FRAC + 50) ? CW + 49 : FRAC + 50) + 3;
	localparam int SH_W  = ACC_W - FRAC;

	logic signed [CW:0]        c_q;
	logic signed [HW-1:0]      w_q;
	logic                      p2_q;
	logic signed [2:0]         m_q;
	logic                      opv_q;
	logic                      ph_q;
	logic                      prodv_q;
	logic                      prodsh_q;
	logic signed [PW-1:0]      prod_q;
	logic signed [ACC_W-1:0]   acc_q;

	logic signed [CW+LO_W+1:0] mul_lo;
	logic signed [CW+HW-LO_W:0] mul_hi;
	logic signed [HW+2:0]      w_m;
	logic signed [PW-1:0]      prod_d;
	logic signed [ACC_W-1:0]   addend;
	logic        [SH_W-1:0]    sh;
	logic        [SH_W-HW:0]   sh_top;
	logic                      fits;

	// Partial products: low half unsigned, high half signed, or a power-of-two tap.
	assign mul_lo = c_q * $signed({1'b0, w_q[LO_W-1:0]});
	assign mul_hi = c_q * $signed(w_q[HW-1:LO_W]);
	assign w_m    = w_q * m_q;

	always_comb begin
		if (p2_q) begin
			prod_d = ph_q ? '0 : (PW'(w_m) <<< FRAC);
		end else begin
			prod_d = ph_q ? PW'(mul_hi) : PW'(mul_lo);
		end
	end

	assign addend = prodsh_q ? (ACC_W'(prod_q) <<< LO_W) : ACC_W'(prod_q);

	// Term sequencing: low half first, then high half.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opv_q   <= 1'b0;
			ph_q    <= 1'b0;
			prodv_q <= 1'b0;
		end else begin
			prodv_q <= opv_q;
			if (ctl.valid) begin
				opv_q <= 1'b1;
				ph_q  <= 1'b0;
			end else if (opv_q && ph_q) begin
				opv_q <= 1'b0;
				ph_q  <= 1'b0;
			end else if (opv_q) begin
				ph_q <= 1'b1;
			end
		end
	end

	// Operands, product register and accumulator.
	always_ff @(posedge clk) begin
		if (ctl.valid) begin
			c_q  <= c_in;
			w_q  <= w_in;
			p2_q <= ctl.p2;
			m_q  <= ctl.m;
		end
		if (opv_q) begin
			prod_q   <= prod_d;
			prodsh_q <= ph_q;
		end
		if (ctl.ld) begin
			acc_q <= ACC_W'(ld_x) <<< FRAC;
		end else if (prodv_q) begin
			acc_q <= acc_q + addend;
		end
	end

	// Floor shift by the fraction width and saturation to 48 bits.
	assign sh     = acc_q[ACC_W-1:FRAC];
	assign sh_top = sh[SH_W-1:HW-1];
	assign fits   = (&sh_top) || !(|sh_top);

	always_comb begin
		if (fits) begin
			sat_val = sh[HW-1:0];
		end else if (sh[SH_W-1]) begin
			sat_val = {1'b1, {(HW-1){1'b0}}};
		end else begin
			sat_val = {1'b0, {(HW-1){1'b1}}};
		end
	end

	assign sts.rdy  = !opv_q || ph_q;
	assign sts.idle = !opv_q && !prodv_q;
	assign sts.clip = !fits;

endmodule

`default_nettype wire

// File: design/butterworth_iir_cascade.sv
// Top level of the cascaded direct-form-II IIR filter: sequencer, memories, MAC.
// Depends on bwic_pkg, bwic_ram, bwic_mac and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// A filter request passes through sections_in_use sections (at most MAX_SECT)
// one at a time. All products go through one shared multiply-accumulate unit that
// forms each coefficient-by-history term as two half products. A section runs
// the feedback, numerator and gain passes, each draining the MAC, then one
// history write per word. Coefficient load and history clear requests give no
// result. Coefficients live in one RAM, history in another; history clear is
// immediate through per-word valid bits. A coefficient that was never loaded
// reads as an undefined value.
module butterworth_iir_cascade #(
	parameter int MAX_SECT    = bwic_pkg::MAX_SECT_DEF,
	parameter int SAMPLE_BITS = bwic_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_BITS   = bwic_pkg::COEF_BITS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   wr_en,
	input  wire logic [bwic_pkg::CFG_IX_W-1:0]          wr_index,
	input  wire logic [bwic_pkg::CFG_W-1:0]             wr_data,
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	// sample_in, section_index, coef_slot, coef_value
	input  wire logic [((SAMPLE_BITS+38+7)/8)*8-1:0]    s_tdata,
	// action
	input  wire logic [1:0]                             s_tuser,
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	// sample_out
	output logic      [((SAMPLE_BITS+7)/8)*8-1:0]       m_tdata,
	// saturated
	output logic                                        m_tuser
);

	localparam int HW     = bwic_pkg::HIST_W;
	localparam int SB     = SAMPLE_BITS;
	localparam int CW     = (COEF_BITS < bwic_pkg::FIELD_W) ? COEF_BITS : bwic_pkg::FIELD_W;
	localparam int FRAC   = COEF_BITS - 6;
	localparam int OUT_TW = ((SB + 7) / 8) * 8;
	localparam int IN_UP  = (SB <= 17) ? 17 - SB : 0;
	localparam int IN_DN  = (SB > 17) ? SB - 17 : 0;
	localparam int CDEPTH = MAX_SECT * bwic_pkg::SLOTS;
	localparam int HDEPTH = MAX_SECT * 4;
	localparam int CA_W   = $clog2(CDEPTH);
	localparam int HA_W   = $clog2(HDEPTH);
	localparam int SW     = (MAX_SECT > 1) ? $clog2(MAX_SECT) : 1;
	localparam int CNT_W  = $clog2(MAX_SECT + 1);

	// Input fields.
	logic signed [SB-1:0] in_sample;
	logic        [2:0]    in_sect;
	logic        [2:0]    in_slot;
	logic        [31:0]   in_coef;

	assign in_sample = s_tdata[SB-1:0];
	assign in_sect   = s_tdata[SB+2:SB];
	assign in_slot   = s_tdata[SB+5:SB+3];
	assign in_coef   = s_tdata[SB+37:SB+6];

	// Configuration registers.
	logic        [1:0]    mode_q;
	logic        [3:0]    secs_q;
	logic signed [CW-1:0] stop_r_q;
	logic signed [CW-1:0] stop_s_q;

	// Sequencer state.
	bwic_pkg::st_t        state_q, state_d;
	logic                 ph_q;
	logic        [2:0]    k_q;
	logic        [CNT_W-1:0] sect_q;
	logic                 sat_q;
	logic                 m_tvalid_q;
	logic        [HDEPTH-1:0] hv_q;

	// Datapath registers.
	logic signed [HW-1:0] x_q;
	logic signed [HW-1:0] v_q;
	logic signed [HW-1:0] words_q [5];
	logic        [SB-1:0] out_q;
	logic                 out_sat_q;
	logic                 hv_rd_q;

	// Memory and MAC connections.
	logic                 coef_we;
	logic [CA_W-1:0]      coef_waddr;
	logic [CA_W-1:0]      coef_raddr;
	logic [CW-1:0]        coef_rdata;
	logic                 hist_we;
	logic [HA_W-1:0]      hist_waddr;
	logic [HA_W-1:0]      hist_raddr;
	logic [HW-1:0]        hist_rdata;
	logic signed [HW-1:0] hist_word;

	bwic_pkg::mac_ctl_t   mac_ctl;
	bwic_pkg::mac_sts_t   mac_sts;
	logic signed [CW:0]   mac_c;
	logic signed [HW-1:0] mac_w;
	logic signed [HW-1:0] mac_ld_x;
	logic signed [HW-1:0] mac_sat;

	// Miscellaneous decode.
	logic                 acc_in;
	logic                 is_filter;
	logic                 ord4;
	logic        [2:0]    n_ord;
	logic        [CNT_W-1:0] cnt;
	logic                 last_sect;
	logic        [SW-1:0] sect_idx;
	logic        [2:0]    km1;
	logic        [2:0]    cslot;
	logic signed [HW-1:0] x_conv;
	logic signed [63:0]   y_w;
	logic        [64-SB:0] y_top;
	logic                 y_fits;
	logic        [SB-1:0] y_sat;
	logic                 out_free;
	logic                 tap_p2;
	logic signed [2:0]    tap_m;
	logic signed [CW:0]   tap_c;

	assign acc_in    = s_tvalid && s_tready;
	assign is_filter = (s_tuser == bwic_pkg::ACT_FILTER);
	assign s_tready  = (state_q == bwic_pkg::ST_IDLE);
	assign ord4      = mode_q[1];
	assign n_ord     = ord4 ? 3'd4 : 3'd2;
	assign sect_idx  = sect_q[SW-1:0];
	assign km1       = k_q - 3'd1;
	assign last_sect = ((sect_q + CNT_W'(1)) == cnt);
	assign out_free  = !m_tvalid_q || m_tready;

	// Effective section count.
	always_comb begin
		if (int'(secs_q) > MAX_SECT) begin
			cnt = CNT_W'(MAX_SECT);
		end else begin
			cnt = CNT_W'(secs_q);
		end
	end

	// Input sample to 16 fraction bits; output back to the sample format.
	assign x_conv = (HW'(in_sample) <<< IN_UP) >>> IN_DN;
	assign y_w    = (64'(x_q) >>> IN_UP) <<< IN_DN;
	assign y_top  = y_w[63:SB-1];
	assign y_fits = (&y_top) || !(|y_top);

	always_comb begin
		if (y_fits) begin
			y_sat = y_w[SB-1:0];
		end else if (y_w[63]) begin
			y_sat = {1'b1, {(SB-1){1'b0}}};
		end else begin
			y_sat = {1'b0, {(SB-1){1'b1}}};
		end
	end

	// Numerator tap of the current term for the selected mode.
	always_comb begin
		tap_p2 = 1'b1;
		tap_m  = bwic_pkg::M_ONE;
		tap_c  = '0;
		unique case (mode_q)
			bwic_pkg::MODE_LP: begin
				if (k_q == 3'd1) tap_m = bwic_pkg::M_TWO;
			end
			bwic_pkg::MODE_HP: begin
				if (k_q == 3'd1) tap_m = bwic_pkg::M_NEG_TWO;
			end
			bwic_pkg::MODE_BP: begin
				if (k_q == 3'd1 || k_q == 3'd3) tap_m = bwic_pkg::M_ZERO;
				if (k_q == 3'd2) tap_m = bwic_pkg::M_NEG_TWO;
			end
			bwic_pkg::MODE_BS: begin
				if (k_q == 3'd1 || k_q == 3'd3) begin
					tap_p2 = 1'b0;
					tap_c  = -((CW + 1)'(stop_r_q));
				end else if (k_q == 3'd2) begin
					tap_p2 = 1'b0;
					tap_c  = (CW + 1)'(stop_s_q);
				end
			end
			default: begin
				tap_p2 = 1'b1;
			end
		endcase
	end

	// History words that were cleared or never written read as zero.
	assign hist_word = hv_rd_q ? $signed(hist_rdata) : '0;

	// Memory addresses.
	assign cslot      = (state_q == bwic_pkg::ST_GAIN) ? bwic_pkg::SLOT_GAIN : k_q;
	assign coef_raddr = CA_W'(CA_W'(sect_idx) * CA_W'(bwic_pkg::SLOTS) + CA_W'(cslot));
	assign coef_waddr = CA_W'(CA_W'(in_sect) * CA_W'(bwic_pkg::SLOTS) + CA_W'(in_slot));
	assign hist_raddr = HA_W'({sect_idx, km1[1:0]});
	assign hist_waddr = HA_W'({sect_idx, k_q[1:0]});

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bwic_pkg::ST_IDLE: begin
				if (acc_in && is_filter) begin
					state_d = (cnt == '0) ? bwic_pkg::ST_OUT : bwic_pkg::ST_FB;
				end
			end
			bwic_pkg::ST_FB: begin
				if (ph_q && k_q == n_ord) state_d = bwic_pkg::ST_FB_END;
			end
			bwic_pkg::ST_FB_END: begin
				if (mac_sts.idle) state_d = bwic_pkg::ST_NUM;
			end
			bwic_pkg::ST_NUM: begin
				if (ph_q && k_q == n_ord) state_d = bwic_pkg::ST_NUM_END;
			end
			bwic_pkg::ST_NUM_END: begin
				if (mac_sts.idle) state_d = bwic_pkg::ST_GAIN;
			end
			bwic_pkg::ST_GAIN: begin
				if (ph_q) state_d = bwic_pkg::ST_GAIN_END;
			end
			bwic_pkg::ST_GAIN_END: begin
				if (mac_sts.idle) state_d = bwic_pkg::ST_WB;
			end
			bwic_pkg::ST_WB: begin
				if (k_q == 3'd0) state_d = last_sect ? bwic_pkg::ST_OUT : bwic_pkg::ST_FB;
			end
			bwic_pkg::ST_OUT: begin
				if (out_free) state_d = bwic_pkg::ST_IDLE;
			end
			default: begin
				state_d = bwic_pkg::ST_IDLE;
			end
		endcase
	end

	// Output logic: memory writes and MAC control.
	always_comb begin
		coef_we     = 1'b0;
		hist_we     = 1'b0;
		mac_ctl     = '0;
		mac_c       = (CW + 1)'($signed(coef_rdata));
		mac_w       = hist_word;
		mac_ld_x    = '0;
		unique case (state_q)
			bwic_pkg::ST_IDLE: begin
				if (acc_in && s_tuser == bwic_pkg::ACT_LOAD && int'(in_sect) < MAX_SECT
						&& int'(in_slot) < bwic_pkg::SLOTS) begin
					coef_we = 1'b1;
				end
				if (acc_in && is_filter && cnt != '0) begin
					mac_ctl.ld = 1'b1;
					mac_ld_x   = x_conv;
				end
			end
			bwic_pkg::ST_FB: begin
				mac_ctl.valid = ph_q;
			end
			bwic_pkg::ST_FB_END, bwic_pkg::ST_NUM_END: begin
				mac_ctl.ld = mac_sts.idle;
			end
			bwic_pkg::ST_NUM: begin
				mac_ctl.valid = ph_q;
				mac_ctl.p2    = tap_p2;
				mac_ctl.m     = tap_m;
				mac_c         = tap_c;
				mac_w         = words_q[k_q];
			end
			bwic_pkg::ST_GAIN: begin
				mac_ctl.valid = ph_q;
				mac_w         = v_q;
			end
			bwic_pkg::ST_WB: begin
				hist_we = 1'b1;
				if (k_q == 3'd0 && !last_sect) begin
					mac_ctl.ld = 1'b1;
					mac_ld_x   = x_q;
				end
			end
			bwic_pkg::ST_GAIN_END, bwic_pkg::ST_OUT: begin
				mac_ctl = '0;
			end
			default: begin
				mac_ctl = '0;
			end
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= '0;
			secs_q   <= '0;
			stop_r_q <= '0;
			stop_s_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				bwic_pkg::REG_MODE:   mode_q   <= wr_data[1:0];
				bwic_pkg::REG_SECTS:  secs_q   <= wr_data[3:0];
				bwic_pkg::REG_STOP_R: stop_r_q <= wr_data[CW-1:0];
				bwic_pkg::REG_STOP_S: stop_s_q <= wr_data[CW-1:0];
				default: begin
					mode_q <= mode_q;
				end
			endcase
		end
	end

	// Sequencer control registers and history valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= bwic_pkg::ST_IDLE;
			ph_q       <= 1'b0;
			k_q        <= '0;
			sect_q     <= '0;
			sat_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
			hv_q       <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				bwic_pkg::ST_IDLE: begin
					ph_q   <= 1'b0;
					k_q    <= 3'd1;
					sect_q <= '0;
					if (acc_in && is_filter) sat_q <= 1'b0;
					if (acc_in && s_tuser == bwic_pkg::ACT_CLEAR) hv_q <= '0;
				end
				bwic_pkg::ST_FB, bwic_pkg::ST_NUM: begin
					ph_q <= ~ph_q;
					if (ph_q && k_q != n_ord) k_q <= k_q + 3'd1;
				end
				bwic_pkg::ST_FB_END, bwic_pkg::ST_NUM_END: begin
					ph_q <= 1'b0;
					k_q  <= '0;
					if (mac_sts.idle && mac_sts.clip) sat_q <= 1'b1;
				end
				bwic_pkg::ST_GAIN: begin
					ph_q <= ~ph_q;
				end
				bwic_pkg::ST_GAIN_END: begin
					ph_q <= 1'b0;
					k_q  <= n_ord - 3'd1;
					if (mac_sts.idle && mac_sts.clip) sat_q <= 1'b1;
				end
				bwic_pkg::ST_WB: begin
					hv_q[hist_waddr] <= 1'b1;
					if (k_q == 3'd0) begin
						k_q    <= 3'd1;
						sect_q <= sect_q + CNT_W'(1);
					end else begin
						k_q <= k_q - 3'd1;
					end
				end
				bwic_pkg::ST_OUT: begin
					ph_q <= 1'b0;
				end
				default: begin
					ph_q <= 1'b0;
				end
			endcase
			if (state_q == bwic_pkg::ST_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		hv_rd_q <= hv_q[hist_raddr];
		if (state_q == bwic_pkg::ST_IDLE && acc_in) begin
			x_q <= x_conv;
		end
		if (state_q == bwic_pkg::ST_FB && ph_q) begin
			words_q[k_q] <= hist_word;
		end
		if (state_q == bwic_pkg::ST_FB_END && mac_sts.idle) begin
			words_q[0] <= mac_sat;
		end
		if (state_q == bwic_pkg::ST_NUM_END && mac_sts.idle) begin
			v_q <= mac_sat;
		end
		if (state_q == bwic_pkg::ST_GAIN_END && mac_sts.idle) begin
			x_q <= mac_sat;
		end
		if (state_q == bwic_pkg::ST_OUT && out_free) begin
			out_q     <= y_sat;
			out_sat_q <= sat_q || !y_fits;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_TW'(out_q);
	assign m_tuser  = out_sat_q;

	// Coefficient table.
	bwic_ram #(
		.WIDTH (CW),
		.DEPTH (CDEPTH)
	) u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.waddr (coef_waddr),
		.wdata (in_coef[CW-1:0]),
		.raddr (coef_raddr),
		.rdata (coef_rdata)
	);

	// History words w1..w4 of every section.
	bwic_ram #(
		.WIDTH (HW),
		.DEPTH (HDEPTH)
	) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata (words_q[k_q]),
		.raddr (hist_raddr),
		.rdata (hist_rdata)
	);

	// Shared multiply-accumulate unit.
	bwic_mac #(
		.CW   (CW),
		.FRAC (FRAC)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mac_ctl),
		.c_in    (mac_c),
		.w_in    (mac_w),
		.ld_x    (mac_ld_x),
		.sts     (mac_sts),
		.sat_val (mac_sat)
	);

	// The sequencer only hands a term to the MAC when it can take one.
	`ASSERT_IMP(a_mac_issue, clk, arst_n, mac_ctl.valid, mac_sts.rdy,
		"MAC term issued while busy")
	// Load, clear and unknown requests produce no result.
	`ASSERT_NXT(a_no_result, clk, arst_n, acc_in && !is_filter,
		m_tvalid == $past(m_tvalid && !m_tready), "result from a non-filter request")
	// The section counter stays within the configured cascade.
	`ASSERT_IMP(a_sect_range, clk, arst_n, state_q == bwic_pkg::ST_FB, sect_q < cnt,
		"section index beyond cascade length")

endmodule

`default_nettype wire
